/* rtl/core/ryuv_pkg.sv */
// Shared constants, types and arithmetic helpers of the RGB to YUV subsampler.
package ryuv_pkg;

	// Fixed-point precision and line geometry
	localparam int FRAC_BITS  = 16;
	localparam int MAX_WIDTH  = 2048;
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int IDX_W      = $clog2(LINE_DEPTH);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int LW_W       = 12;
	localparam int Y_W        = FRAC_BITS + 9;
	localparam int CH_W       = FRAC_BITS + 10;
	localparam int PAIR_W     = CH_W + 1;
	localparam int QUAD_W     = CH_W + 2;
	localparam int LINE_W     = 2 * PAIR_W;

	localparam logic [LW_W-1:0] LW_RESET = LW_W'(640);
	localparam logic [LW_W-1:0] LW_MIN   = LW_W'(2);
	localparam logic [LW_W-1:0] LW_MAX   = LW_W'(MAX_WIDTH);

	// Coefficients: unsigned magnitudes, rounded to nearest
	localparam logic [FRAC_BITS-1:0] K_YR =
		FRAC_BITS'(((64'd29900 << FRAC_BITS) + 64'd50000) / 64'd100000);
	localparam logic [FRAC_BITS-1:0] K_YG =
		FRAC_BITS'(((64'd58700 << FRAC_BITS) + 64'd50000) / 64'd100000);
	localparam logic [FRAC_BITS-1:0] K_YB =
		FRAC_BITS'(((64'd11400 << FRAC_BITS) + 64'd50000) / 64'd100000);
	localparam logic [FRAC_BITS-1:0] K_UR =
		FRAC_BITS'(((64'd14713 << FRAC_BITS) + 64'd50000) / 64'd100000);
	localparam logic [FRAC_BITS-1:0] K_UG =
		FRAC_BITS'(((64'd28886 << FRAC_BITS) + 64'd50000) / 64'd100000);
	localparam logic [FRAC_BITS-1:0] K_UB =
		FRAC_BITS'(((64'd43600 << FRAC_BITS) + 64'd50000) / 64'd100000);
	localparam logic [FRAC_BITS-1:0] K_VR =
		FRAC_BITS'(((64'd61500 << FRAC_BITS) + 64'd50000) / 64'd100000);
	localparam logic [FRAC_BITS-1:0] K_VG =
		FRAC_BITS'(((64'd51499 << FRAC_BITS) + 64'd50000) / 64'd100000);
	localparam logic [FRAC_BITS-1:0] K_VB =
		FRAC_BITS'(((64'd10001 << FRAC_BITS) + 64'd50000) / 64'd100000);

	// Chroma formats
	typedef enum logic [1:0] {
		MODE_444 = 2'd0,
		MODE_422 = 2'd1,
		MODE_420 = 2'd2
	} mode_t;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = LW_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE       = 1'b0,
		REG_LINE_WIDTH = 1'b1
	} reg_idx_t;

	// Per-pixel control carried down the pipeline
	typedef struct packed {
		logic             odd_col;
		logic             odd_row;
		mode_t            mode;
		logic [IDX_W-1:0] idx;
	} ctl_t;

	// Arithmetic shift right that truncates toward zero
	function automatic logic signed [QUAD_W-1:0] trunc_shift(
		input logic signed [QUAD_W-1:0] x,
		input int                       sh
	);
		logic signed [QUAD_W-1:0] bias;
		bias = '0;
		if (x[QUAD_W-1])
			bias = (QUAD_W'(1) << sh) - QUAD_W'(1);
		return (x + bias) >>> sh;
	endfunction

	// Saturate to signed 8 bits
	function automatic logic signed [7:0] sat8(input logic signed [QUAD_W-1:0] x);
		logic signed [7:0] r;
		if (x > QUAD_W'(127))
			r = 8'sd127;
		else if (x < QUAD_W'(-128))
			r = -8'sd128;
		else
			r = x[7:0];
		return r;
	endfunction

endpackage

/* rtl/core/ryuv_if.sv */
// Valid/ready channels of the subsampler: pixel input, YUV output, register writes.
interface ryuv_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       frame_start;

	modport source (output valid, red, green, blue, frame_start, input ready);
	modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface ryuv_yuv_if;
	logic              valid;
	logic              ready;
	logic [7:0]        luma;
	logic signed [7:0] chroma_u;
	logic signed [7:0] chroma_v;
	logic              chroma_valid;

	modport source (output valid, luma, chroma_u, chroma_v, chroma_valid, input ready);
	modport sink   (input valid, luma, chroma_u, chroma_v, chroma_valid, output ready);
endinterface

interface ryuv_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [ryuv_pkg::CFG_IDX_W-1:0]      index;
	logic [ryuv_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/ryuv_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module ryuv_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	// Write, and register the read word (old data on a same-address collision)
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

/* rtl/core/rgb_to_yuv_subsampler.sv */
// Top level: BT.601 RGB to YUV conversion with 4:4:4, 4:2:2 and 4:2:0 chroma output.
//
// Takes one raster-order RGB pixel per clock while the output is not stalled and returns
// one word per pixel: its luma and, when a pixel, a horizontal pair (4:2:2) or a 2x2 block
// (4:2:0) completes, a saturated signed chroma sample flagged by chroma_valid (chroma reads
// zero otherwise). The pipeline is two stages and an output register: stage 1 holds the
// pixel, forms Y, U and V with constant multipliers and takes the line-store word read at
// accept; stage 2 combines pairs and blocks, writes top-row pair sums back to the line store
// and fills the output register. A result passes stage 1, stage 2 and the output register
// before it is presented; backpressure stalls only the stages that are full. The line store
// is a 1024 x 54 RAM with a registered read and no clearing pass, so it is ready right after
// reset; a 4:2:0 odd row must follow the even row that filled it. The user must write mode
// (index 0) and line_width (index 1) only while no pixel is in flight; the block itself does
// not enforce it. An odd width loses its low bit and the width is held within 2 to 2048.
module rgb_to_yuv_subsampler (
	input  logic         clk,
	input  logic         arst_n,
	ryuv_cfg_if.sink     cfg,
	ryuv_pix_if.sink     pix,
	ryuv_yuv_if.source   yuv
);

	// Configuration registers
	ryuv_pkg::mode_t                mode_q;
	logic [ryuv_pkg::LW_W-1:0]      line_width_q;

	// Raster position
	logic [ryuv_pkg::COL_W-1:0]     col_q;
	logic                           row_q;

	// Pipeline control
	logic                           valid_s1;
	logic                           valid_s2;
	logic                           out_v_q;
	logic                           adv_s1;
	logic                           adv_s2;
	logic                           adv_out;
	logic                           acc;
	logic                           s2_fire;

	// Position decode at accept
	logic [ryuv_pkg::COL_W-1:0]     col_eff;
	logic                           row_eff;
	logic [ryuv_pkg::LW_W-1:0]      lw_even;
	logic [ryuv_pkg::LW_W-1:0]      width_eff;
	logic [ryuv_pkg::LW_W-1:0]      col_inc;
	logic                           wrap;

	// Stage 1
	ryuv_pkg::ctl_t                 ctl_s1;
	logic [7:0]                     red_s1;
	logic [7:0]                     green_s1;
	logic [7:0]                     blue_s1;
	logic [ryuv_pkg::Y_W-1:0]       y_sum;
	logic [8:0]                     y_int;
	logic [7:0]                     luma_calc;
	logic [ryuv_pkg::CH_W-1:0]      u_calc;
	logic [ryuv_pkg::CH_W-1:0]      v_calc;
	logic [ryuv_pkg::LINE_W-1:0]    ram_rdata;
	logic [ryuv_pkg::LINE_W-1:0]    line_s1;

	// Line-store write forwarding
	logic                           fwd_v_q;
	logic [ryuv_pkg::IDX_W-1:0]     fwd_idx_q;
	logic [ryuv_pkg::LINE_W-1:0]    fwd_data_q;

	// Stage 2
	ryuv_pkg::ctl_t                 ctl_s2;
	logic [7:0]                     luma_s2;
	logic signed [ryuv_pkg::CH_W-1:0]   u_s2;
	logic signed [ryuv_pkg::CH_W-1:0]   v_s2;
	logic [ryuv_pkg::LINE_W-1:0]        line_s2;
	logic signed [ryuv_pkg::PAIR_W-1:0] line_u;
	logic signed [ryuv_pkg::PAIR_W-1:0] line_v;

	// Pair state: first pixel of the pair, full and truncated-half forms
	logic signed [ryuv_pkg::CH_W-1:0]   pf_u_q;
	logic signed [ryuv_pkg::CH_W-1:0]   pf_v_q;
	logic signed [ryuv_pkg::QUAD_W-1:0] pft_u_q;
	logic signed [ryuv_pkg::QUAD_W-1:0] pft_v_q;

	// Stage 2 arithmetic
	logic signed [ryuv_pkg::PAIR_W-1:0] su;
	logic signed [ryuv_pkg::PAIR_W-1:0] sv;
	logic signed [ryuv_pkg::QUAD_W-1:0] quad_u;
	logic signed [ryuv_pkg::QUAD_W-1:0] quad_v;
	logic signed [ryuv_pkg::QUAD_W-1:0] half_u;
	logic signed [ryuv_pkg::QUAD_W-1:0] half_v;
	logic signed [ryuv_pkg::QUAD_W-1:0] cu_raw;
	logic signed [ryuv_pkg::QUAD_W-1:0] cv_raw;
	logic                               cvalid;
	logic                               ram_we;

	// Output register
	logic [7:0]                     luma_q;
	logic signed [7:0]              cu_q;
	logic signed [7:0]              cv_q;
	logic                           cvalid_q;

	// Handshake: each stage moves when the one after it is empty or moving
	assign adv_out   = !out_v_q || yuv.ready;
	assign adv_s2    = !valid_s2 || adv_out;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign pix.ready = adv_s1;
	assign acc       = pix.valid && adv_s1;
	assign s2_fire   = valid_s2 && adv_out;
	assign cfg.ready = 1'b1;

	// Decode position of the incoming pixel and the next column
	always_comb begin
		col_eff = pix.frame_start ? '0 : col_q;
		row_eff = pix.frame_start ? 1'b0 : row_q;
		lw_even = {line_width_q[ryuv_pkg::LW_W-1:1], 1'b0};
		if (lw_even < ryuv_pkg::LW_MIN)
			width_eff = ryuv_pkg::LW_MIN;
		else if (lw_even > ryuv_pkg::LW_MAX)
			width_eff = ryuv_pkg::LW_MAX;
		else
			width_eff = lw_even;
		col_inc = ryuv_pkg::LW_W'(col_eff) + ryuv_pkg::LW_W'(1);
		wrap    = col_inc >= width_eff;
	end

	// Control registers: configuration, position, stage valids, forwarding tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= ryuv_pkg::MODE_444;
			line_width_q <= ryuv_pkg::LW_RESET;
			col_q        <= '0;
			row_q        <= 1'b0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			out_v_q      <= 1'b0;
			fwd_v_q      <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (ryuv_pkg::reg_idx_t'(cfg.index))
					ryuv_pkg::REG_MODE: begin
						mode_q <= ryuv_pkg::mode_t'(cfg.data[1:0]);
					end
					ryuv_pkg::REG_LINE_WIDTH: begin
						line_width_q <= cfg.data;
					end
				endcase
			end
			if (acc) begin
				col_q <= wrap ? '0 : col_inc[ryuv_pkg::COL_W-1:0];
				row_q <= row_eff ^ wrap;
			end
			if (adv_s1)
				valid_s1 <= acc;
			if (adv_s2)
				valid_s2 <= valid_s1;
			if (adv_out)
				out_v_q <= valid_s2;
			if (ram_we)
				fwd_v_q <= 1'b1;
		end
	end

	// Line store of top-row pair sums, {u, v}
	ryuv_ram #(
		.W     (ryuv_pkg::LINE_W),
		.DEPTH (ryuv_pkg::LINE_DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ctl_s2.idx),
		.wdata ({su, sv}),
		.re    (acc),
		.raddr (col_eff[ryuv_pkg::COL_W-1:1]),
		.rdata (ram_rdata)
	);

	// Stage 1: constant-coefficient products and sums; bypass a write the read missed
	always_comb begin
		y_sum = ryuv_pkg::Y_W'(ryuv_pkg::K_YR) * ryuv_pkg::Y_W'(red_s1)
		      + ryuv_pkg::Y_W'(ryuv_pkg::K_YG) * ryuv_pkg::Y_W'(green_s1)
		      + ryuv_pkg::Y_W'(ryuv_pkg::K_YB) * ryuv_pkg::Y_W'(blue_s1);
		y_int     = y_sum[ryuv_pkg::Y_W-1:ryuv_pkg::FRAC_BITS];
		luma_calc = y_int[8] ? 8'hFF : y_int[7:0];
		u_calc = ryuv_pkg::CH_W'(ryuv_pkg::K_UB) * ryuv_pkg::CH_W'(blue_s1)
		       - ryuv_pkg::CH_W'(ryuv_pkg::K_UR) * ryuv_pkg::CH_W'(red_s1)
		       - ryuv_pkg::CH_W'(ryuv_pkg::K_UG) * ryuv_pkg::CH_W'(green_s1);
		v_calc = ryuv_pkg::CH_W'(ryuv_pkg::K_VR) * ryuv_pkg::CH_W'(red_s1)
		       - ryuv_pkg::CH_W'(ryuv_pkg::K_VG) * ryuv_pkg::CH_W'(green_s1)
		       - ryuv_pkg::CH_W'(ryuv_pkg::K_VB) * ryuv_pkg::CH_W'(blue_s1);
		line_s1 = (fwd_v_q && fwd_idx_q == ctl_s1.idx) ? fwd_data_q : ram_rdata;
	end

	// Stage 2: combine pair and block, pick the chroma result
	always_comb begin
		line_u = line_s2[ryuv_pkg::LINE_W-1:ryuv_pkg::PAIR_W];
		line_v = line_s2[ryuv_pkg::PAIR_W-1:0];
		su     = ryuv_pkg::PAIR_W'(pf_u_q) + ryuv_pkg::PAIR_W'(u_s2);
		sv     = ryuv_pkg::PAIR_W'(pf_v_q) + ryuv_pkg::PAIR_W'(v_s2);
		quad_u = ryuv_pkg::QUAD_W'(line_u) + ryuv_pkg::QUAD_W'(su);
		quad_v = ryuv_pkg::QUAD_W'(line_v) + ryuv_pkg::QUAD_W'(sv);
		half_u = pft_u_q + ryuv_pkg::QUAD_W'(u_s2);
		half_v = pft_v_q + ryuv_pkg::QUAD_W'(v_s2);
		ram_we = 1'b0;
		case (ctl_s2.mode)
			ryuv_pkg::MODE_422: begin
				cu_raw = ryuv_pkg::trunc_shift(half_u, ryuv_pkg::FRAC_BITS + 1);
				cv_raw = ryuv_pkg::trunc_shift(half_v, ryuv_pkg::FRAC_BITS + 1);
				cvalid = ctl_s2.odd_col;
			end
			ryuv_pkg::MODE_420: begin
				cu_raw = ryuv_pkg::trunc_shift(quad_u, ryuv_pkg::FRAC_BITS + 2);
				cv_raw = ryuv_pkg::trunc_shift(quad_v, ryuv_pkg::FRAC_BITS + 2);
				cvalid = ctl_s2.odd_col && ctl_s2.odd_row;
				ram_we = s2_fire && ctl_s2.odd_col && !ctl_s2.odd_row;
			end
			default: begin
				cu_raw = ryuv_pkg::trunc_shift(ryuv_pkg::QUAD_W'(u_s2), ryuv_pkg::FRAC_BITS);
				cv_raw = ryuv_pkg::trunc_shift(ryuv_pkg::QUAD_W'(v_s2), ryuv_pkg::FRAC_BITS);
				cvalid = 1'b1;
			end
		endcase
	end

	// Payload registers: stage data, pair state, forwarding data, output word
	always_ff @(posedge clk) begin
		if (acc) begin
			red_s1         <= pix.red;
			green_s1       <= pix.green;
			blue_s1        <= pix.blue;
			ctl_s1.odd_col <= col_eff[0];
			ctl_s1.odd_row <= row_eff;
			ctl_s1.mode    <= mode_q;
			ctl_s1.idx     <= col_eff[ryuv_pkg::COL_W-1:1];
		end
		if (adv_s2 && valid_s1) begin
			ctl_s2  <= ctl_s1;
			luma_s2 <= luma_calc;
			u_s2    <= $signed(u_calc);
			v_s2    <= $signed(v_calc);
			line_s2 <= line_s1;
		end
		if (s2_fire && !ctl_s2.odd_col) begin
			pf_u_q  <= u_s2;
			pf_v_q  <= v_s2;
			pft_u_q <= ryuv_pkg::trunc_shift(ryuv_pkg::QUAD_W'(u_s2), ryuv_pkg::FRAC_BITS + 1)
			           <<< (ryuv_pkg::FRAC_BITS + 1);
			pft_v_q <= ryuv_pkg::trunc_shift(ryuv_pkg::QUAD_W'(v_s2), ryuv_pkg::FRAC_BITS + 1)
			           <<< (ryuv_pkg::FRAC_BITS + 1);
		end
		if (ram_we) begin
			fwd_idx_q  <= ctl_s2.idx;
			fwd_data_q <= {su, sv};
		end
		if (s2_fire) begin
			luma_q   <= luma_s2;
			cu_q     <= cvalid ? ryuv_pkg::sat8(cu_raw) : 8'sd0;
			cv_q     <= cvalid ? ryuv_pkg::sat8(cv_raw) : 8'sd0;
			cvalid_q <= cvalid;
		end
	end

	// Drive the output channel
	assign yuv.valid        = out_v_q;
	assign yuv.luma         = luma_q;
	assign yuv.chroma_u     = cu_q;
	assign yuv.chroma_v     = cv_q;
	assign yuv.chroma_valid = cvalid_q;

	// An empty chroma slot carries zeros
	a_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !cvalid_q) |-> (cu_q == 8'sd0 && cv_q == 8'sd0))
		else $error("chroma not zero on a word without a chroma sample");

	// An accepted pixel occupies stage 1 on the next cycle
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> valid_s1)
		else $error("accepted pixel lost before stage 1");

	// An output word appears only from a full stage 2
	a_out_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(valid_s2))
		else $error("output word raised without a stage 2 word");

endmodule

/* tb/sv/rgb_to_yuv_subsampler_tb.sv */
// Testbench of rgb_to_yuv_subsampler: paced pixel driver, YUV checker with a predictor.
module rgb_to_yuv_subsampler_tb;

	localparam int FRAC        = 16;
	localparam int WIDEST_LINE = 2048;
	localparam int LINE_PAIRS  = WIDEST_LINE / 2;
	localparam int PHASES      = 11;

	// Chroma format code with no name of its own: behaves as 4:4:4
	localparam logic [1:0] MODE_SPARE = 2'd3;

	function automatic longint fixed_coef(input longint hundred_thousandths);
		return ((hundred_thousandths << FRAC) + 64'd50000) / 64'd100000;
	endfunction

	localparam longint KY_R = fixed_coef(29900);
	localparam longint KY_G = fixed_coef(58700);
	localparam longint KY_B = fixed_coef(11400);
	localparam longint KU_R = fixed_coef(14713);
	localparam longint KU_G = fixed_coef(28886);
	localparam longint KU_B = fixed_coef(43600);
	localparam longint KV_R = fixed_coef(61500);
	localparam longint KV_G = fixed_coef(51499);
	localparam longint KV_B = fixed_coef(10001);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_start;
	} pixel_t;

	typedef struct packed {
		logic [7:0]        luma;
		logic signed [7:0] chroma_u;
		logic signed [7:0] chroma_v;
		logic              chroma_valid;
	} yuv_word_t;

	logic clk = 1'b0;
	logic arst_n;

	ryuv_pix_if pix_ch ();
	ryuv_yuv_if yuv_ch ();
	ryuv_cfg_if cfg_ch ();

	rgb_to_yuv_subsampler i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.pix    (pix_ch),
		.yuv    (yuv_ch)
	);

	// Register shadows, written at the config handshake
	logic [1:0]  mode_cfg;
	logic [11:0] width_cfg;

	// Converter state, advanced at each accepted pixel
	int     conv_col;
	bit     conv_odd_row;
	longint conv_pair_u;
	longint conv_pair_v;
	longint conv_line_u [LINE_PAIRS];
	longint conv_line_v [LINE_PAIRS];

	// Raster position seen by the stimulus, to keep 4:2:0 reads on written entries
	int plan_col;
	bit plan_odd_row;
	bit plan_written [LINE_PAIRS];

	pixel_t    pixel_backlog [$];
	yuv_word_t yuv_expected [$];
	pixel_t    offer;
	yuv_word_t want;
	int        send_idle_pct;
	int        stall_pct;
	int        mismatch_count;
	int        words_seen;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int line_pixels();
		int w;
		w = int'(width_cfg) & ~1;
		if (w < 2)
			w = 2;
		if (w > WIDEST_LINE)
			w = WIDEST_LINE;
		return w;
	endfunction

	function automatic longint toward_zero(input longint x, input int sh);
		return (x < 0) ? -((-x) >>> sh) : (x >>> sh);
	endfunction

	function automatic logic signed [7:0] clamp_s8(input longint x);
		if (x > 127)
			return 8'sd127;
		if (x < -128)
			return -8'sd128;
		return x[7:0];
	endfunction

	// Convert one pixel and advance the raster position
	function automatic yuv_word_t convert_pixel(input pixel_t px);
		longint    r, g, b, y, u, v, cu, cv, su, sv, au, av;
		int        idx;
		bit        done;
		yuv_word_t w;
		r = longint'(px.red);
		g = longint'(px.green);
		b = longint'(px.blue);
		cu = 0;
		cv = 0;
		done = 1'b0;
		if (px.frame_start) begin
			conv_col = 0;
			conv_odd_row = 1'b0;
		end
		y = (KY_R * r + KY_G * g + KY_B * b) >>> FRAC;
		if (y > 255)
			y = 255;
		u = -KU_R * r - KU_G * g + KU_B * b;
		v = KV_R * r - KV_G * g - KV_B * b;
		idx = conv_col >> 1;
		if (idx >= LINE_PAIRS)
			idx = LINE_PAIRS - 1;
		case (mode_cfg)
			ryuv_pkg::MODE_422: begin
				if (conv_col % 2 == 0) begin
					conv_pair_u = u;
					conv_pair_v = v;
				end else begin
					// halve the first pixel, then add half of the second
					au = toward_zero(conv_pair_u, FRAC + 1);
					av = toward_zero(conv_pair_v, FRAC + 1);
					cu = toward_zero(au * (longint'(1) << (FRAC + 1)) + u, FRAC + 1);
					cv = toward_zero(av * (longint'(1) << (FRAC + 1)) + v, FRAC + 1);
					done = 1'b1;
				end
			end
			ryuv_pkg::MODE_420: begin
				if (conv_col % 2 == 0) begin
					conv_pair_u = u;
					conv_pair_v = v;
				end else begin
					su = conv_pair_u + u;
					sv = conv_pair_v + v;
					if (!conv_odd_row) begin
						conv_line_u[idx] = su;
						conv_line_v[idx] = sv;
					end else begin
						cu = toward_zero(conv_line_u[idx] + su, FRAC + 2);
						cv = toward_zero(conv_line_v[idx] + sv, FRAC + 2);
						done = 1'b1;
					end
				end
			end
			default: begin
				if (conv_col % 2 == 0) begin
					conv_pair_u = u;
					conv_pair_v = v;
				end
				cu = toward_zero(u, FRAC);
				cv = toward_zero(v, FRAC);
				done = 1'b1;
			end
		endcase
		conv_col++;
		if (conv_col >= line_pixels()) begin
			conv_col = 0;
			conv_odd_row = !conv_odd_row;
		end
		w.luma = y[7:0];
		w.chroma_u = done ? clamp_s8(cu) : 8'sd0;
		w.chroma_v = done ? clamp_s8(cv) : 8'sd0;
		w.chroma_valid = done;
		return w;
	endfunction

	// Force a frame start where a 4:2:0 bottom row would read an unwritten pair sum
	function automatic bit plan_position(input bit fs);
		int idx;
		idx = plan_col >> 1;
		if (idx >= LINE_PAIRS)
			idx = LINE_PAIRS - 1;
		if (mode_cfg == ryuv_pkg::MODE_420 && plan_col % 2 == 1 && plan_odd_row
		    && !plan_written[idx])
			fs = 1'b1;
		if (fs) begin
			plan_col = 0;
			plan_odd_row = 1'b0;
			idx = 0;
		end
		if (mode_cfg == ryuv_pkg::MODE_420 && plan_col % 2 == 1 && !plan_odd_row)
			plan_written[idx] = 1'b1;
		plan_col++;
		if (plan_col >= line_pixels()) begin
			plan_col = 0;
			plan_odd_row = !plan_odd_row;
		end
		return fs;
	endfunction

	task automatic push_pixel(input logic [7:0] r, g, b, input bit fs);
		pixel_t px;
		px.red = r;
		px.green = g;
		px.blue = b;
		px.frame_start = plan_position(fs);
		pixel_backlog.push_back(px);
	endtask

	// Mix of saturated corners and full-range colors, rare frame starts
	task automatic push_random();
		logic [7:0] r, g, b;
		if ($urandom_range(3) == 0) begin
			r = $urandom_range(1) ? 8'hFF : 8'h00;
			g = $urandom_range(1) ? 8'hFF : 8'h00;
			b = $urandom_range(1) ? 8'hFF : 8'h00;
		end else begin
			r = 8'($urandom);
			g = 8'($urandom);
			b = 8'($urandom);
		end
		push_pixel(r, g, b, $urandom_range(149) == 0);
	endtask

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("word %0d at %0t: %s", words_seen, $time, msg);
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pixel_backlog.size() != 0 || pix_ch.valid || yuv_expected.size() != 0);
	endtask

	task automatic write_reg(input ryuv_pkg::reg_idx_t idx, input logic [11:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			ryuv_pkg::REG_MODE:       mode_cfg = val[1:0];
			ryuv_pkg::REG_LINE_WIDTH: width_cfg = val;
			default: ;
		endcase
	endtask

	// Drive pixels from the backlog; predict each word as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
		end else if (!pix_ch.valid || pix_ch.ready) begin
			if (pix_ch.valid)
				yuv_expected.push_back(convert_pixel(offer));
			if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				offer = pixel_backlog.pop_front();
				pix_ch.valid <= 1'b1;
				pix_ch.red <= offer.red;
				pix_ch.green <= offer.green;
				pix_ch.blue <= offer.blue;
				pix_ch.frame_start <= offer.frame_start;
			end else begin
				pix_ch.valid <= 1'b0;
			end
		end
	end

	// Take YUV words at random and compare with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yuv_ch.ready <= 1'b0;
		end else begin
			if (yuv_ch.valid && yuv_ch.ready) begin
				if (yuv_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected word, luma %0d", yuv_ch.luma));
				end else begin
					want = yuv_expected.pop_front();
					if (yuv_ch.luma !== want.luma)
						report_mismatch($sformatf("luma %0d, want %0d",
							yuv_ch.luma, want.luma));
					if (yuv_ch.chroma_u !== want.chroma_u)
						report_mismatch($sformatf("chroma_u %0d, want %0d",
							yuv_ch.chroma_u, want.chroma_u));
					if (yuv_ch.chroma_v !== want.chroma_v)
						report_mismatch($sformatf("chroma_v %0d, want %0d",
							yuv_ch.chroma_v, want.chroma_v));
					if (yuv_ch.chroma_valid !== want.chroma_valid)
						report_mismatch($sformatf("chroma_valid %0b, want %0b",
							yuv_ch.chroma_valid, want.chroma_valid));
				end
				words_seen++;
			end
			yuv_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin : stimulus
		logic [1:0]  phase_mode [PHASES];
		logic [11:0] phase_width [PHASES];
		int          phase_len [PHASES];
		int          p;
		int          k;
		phase_mode = '{ryuv_pkg::MODE_444, ryuv_pkg::MODE_422, ryuv_pkg::MODE_420,
			ryuv_pkg::MODE_420, MODE_SPARE, ryuv_pkg::MODE_422, ryuv_pkg::MODE_420,
			ryuv_pkg::MODE_444, ryuv_pkg::MODE_422, ryuv_pkg::MODE_420, ryuv_pkg::MODE_420};
		phase_width = '{12'd2048, 12'd6, 12'd8, 12'd2, 12'd13, 12'd0,
			12'd100, 12'd1, 12'd4095, 12'd30, 12'd4095};
		phase_len = '{150, 150, 250, 120, 100, 100, 300, 80, 120, 300, 150};
		arst_n = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.red = '0;
		pix_ch.green = '0;
		pix_ch.blue = '0;
		pix_ch.frame_start = 1'b0;
		yuv_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = ryuv_pkg::REG_MODE;
		cfg_ch.data = '0;
		mode_cfg = ryuv_pkg::MODE_444;
		width_cfg = 12'd640;
		conv_col = 0;
		conv_odd_row = 1'b0;
		conv_pair_u = 0;
		conv_pair_v = 0;
		plan_col = 0;
		plan_odd_row = 1'b0;
		foreach (plan_written[i])
			plan_written[i] = 1'b0;
		mismatch_count = 0;
		words_seen = 0;
		send_idle_pct = 33;
		stall_pct = 67;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset settings: 4:4:4 over the color cube corners
		push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
		push_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
		push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
		push_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
		push_pixel(8'h00, 8'hFF, 8'hFF, 1'b0);
		push_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
		push_pixel(8'hFF, 8'hFF, 8'h00, 1'b0);
		wait_idle();

		// 4:2:2 pairs, saturating V and negative U
		write_reg(ryuv_pkg::REG_MODE, 12'(ryuv_pkg::MODE_422));
		write_reg(ryuv_pkg::REG_LINE_WIDTH, 12'd4);
		push_pixel(8'hFF, 8'h00, 8'h00, 1'b1);
		push_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
		push_pixel(8'h00, 8'hFF, 8'hFF, 1'b0);
		push_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
		wait_idle();

		// 4:2:0 with an odd width that drops to two: one saturated block
		write_reg(ryuv_pkg::REG_MODE, 12'(ryuv_pkg::MODE_420));
		write_reg(ryuv_pkg::REG_LINE_WIDTH, 12'd3);
		push_pixel(8'hFF, 8'h00, 8'h00, 1'b1);
		repeat (3)
			push_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
		wait_idle();

		// spare mode code with a zero width
		write_reg(ryuv_pkg::REG_MODE, 12'(MODE_SPARE));
		write_reg(ryuv_pkg::REG_LINE_WIDTH, 12'd0);
		push_pixel(8'h00, 8'hFF, 8'hFF, 1'b1);
		push_pixel(8'h11, 8'h22, 8'h33, 1'b0);
		wait_idle();

		// narrow the line while the column sits past the new width
		write_reg(ryuv_pkg::REG_MODE, 12'(ryuv_pkg::MODE_422));
		write_reg(ryuv_pkg::REG_LINE_WIDTH, 12'd4095);
		push_pixel(8'h80, 8'h40, 8'h20, 1'b1);
		repeat (4)
			push_random();
		wait_idle();
		write_reg(ryuv_pkg::REG_LINE_WIDTH, 12'd2);
		repeat (3)
			push_random();
		wait_idle();

		// random phases; each starts wherever the last one left the raster
		for (p = 0; p < PHASES; p++) begin
			if (p == 4) begin
				send_idle_pct = 67;
				stall_pct = 33;
			end else if (p == 8) begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			write_reg(ryuv_pkg::REG_MODE, 12'(phase_mode[p]));
			write_reg(ryuv_pkg::REG_LINE_WIDTH, phase_width[p]);
			for (k = 0; k < phase_len[p]; k++)
				push_random();
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (yuv_expected.size() != 0)
			report_mismatch($sformatf("%0d words never came", yuv_expected.size()));
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : watchdog
		#400000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
